### rtl/fir5_pkg.sv
// shared types and constants for the five-tap fir filter
package fir5_pkg;

  localparam int COEF_WIDTH  = 16;
  localparam int COEF_FRAC   = 14;
  localparam int NUM_COEFS   = 5;
  localparam int ORDER_WIDTH = 3;
  localparam int ADDR_WIDTH  = 5;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_WIDTH   = 3;
  localparam int ROUND_BIAS  = 1 << (COEF_FRAC - 1);

  localparam logic [IDX_WIDTH-1:0] REG_ORDER = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_COEF0 = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_COEF1 = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_COEF2 = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_COEF3 = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_COEF4 = 3'd5;

  localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 3'd4;
  localparam logic [COEF_WIDTH-1:0]  COEF0_RESET = 16'd16384;

  typedef logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_set_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### rtl/fir5_regs.sv
// apb configuration registers: filter order and tap coefficients
module fir5_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fir5_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [fir5_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [fir5_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  output logic [fir5_pkg::ORDER_WIDTH-1:0] order,
  output fir5_pkg::coef_set_t              coefs
);
  import fir5_pkg::*;

  logic [IDX_WIDTH-1:0] idx;
  logic                 wr;

  assign idx    = paddr[ADDR_WIDTH-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORDER_RESET;
      coefs <= coef_set_t'(COEF0_RESET);
    end else if (wr) begin
      unique case (idx)
        REG_ORDER: order    <= pwdata[ORDER_WIDTH-1:0];
        REG_COEF0: coefs[0] <= pwdata[COEF_WIDTH-1:0];
        REG_COEF1: coefs[1] <= pwdata[COEF_WIDTH-1:0];
        REG_COEF2: coefs[2] <= pwdata[COEF_WIDTH-1:0];
        REG_COEF3: coefs[3] <= pwdata[COEF_WIDTH-1:0];
        REG_COEF4: coefs[4] <= pwdata[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORDER: prdata = DATA_WIDTH'(order);
      REG_COEF0: prdata = DATA_WIDTH'(coefs[0]);
      REG_COEF1: prdata = DATA_WIDTH'(coefs[1]);
      REG_COEF2: prdata = DATA_WIDTH'(coefs[2]);
      REG_COEF3: prdata = DATA_WIDTH'(coefs[3]);
      REG_COEF4: prdata = DATA_WIDTH'(coefs[4]);
      default:   prdata = '0;
    endcase
  end

endmodule

### rtl/fir5_cell.sv
// one tap cell: delay register handed to the neighbor (none when HAS_TAP is 0) and a registered product
module fir5_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter bit HAS_TAP      = 1'b1
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  fir5_pkg::cell_ctrl_t                                ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]                      data_in,
  input  logic signed [fir5_pkg::COEF_WIDTH-1:0]              coef,
  output logic signed [SAMPLE_WIDTH-1:0]                      tap_out,
  output logic signed [SAMPLE_WIDTH+fir5_pkg::COEF_WIDTH-1:0] prod
);
  import fir5_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod <= data_in * coef;
    end
  end

  generate
    if (HAS_TAP) begin : g_tap
      always_ff @(posedge clk) begin
        if (rst) begin
          tap_out <= '0;
        end else if (ctrl.shift) begin
          tap_out <= data_in;
        end
      end
    end else begin : g_no_tap
      assign tap_out = '0;
    end
  endgenerate

endmodule

### rtl/fir_filter_five_tap.sv
// five-tap direct-form fir filter, chain of tap cells with rounding and saturation
// registers on the path: the cell products, then the sum, then the output register
// throughput: one item per cycle while not stalled; products, adder, round/saturate
// reset: history and fill count clear, pipeline empties, order 4, coef_zero 1.0
// until enough samples arrive the input passes through with warming set
module fir_filter_five_tap #(
  parameter int MAX_ORDER    = 4,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [SAMPLE_WIDTH-1:0]  filtered_out,
  output logic                            warming,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fir5_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [fir5_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [fir5_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready
);
  import fir5_pkg::*;

  localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W = PW + $clog2(MAX_ORDER + 1);
  localparam int RW    = ACC_W + 1;
  localparam int QW    = RW - COEF_FRAC;
  localparam int CNT_W = $clog2(MAX_ORDER + 1);
  localparam int OW    = (CNT_W > ORDER_WIDTH) ? CNT_W : ORDER_WIDTH;

  logic [ORDER_WIDTH-1:0] order;
  coef_set_t              coefs;

  fir5_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .order   (order),
    .coefs   (coefs)
  );

  logic adv1, adv2, adv3, accept;
  logic v1, v2;

  assign adv3         = !result_valid || !result_stall;
  assign adv2         = !v2 || adv3;
  assign adv1         = !v1 || adv2;
  assign sample_stall = !adv1;
  assign accept       = sample_valid && adv1;

  cell_ctrl_t ctrl;
  assign ctrl.shift = accept;
  assign ctrl.load  = adv1;

  logic [OW-1:0] ext_order, eff_order;
  always_comb begin
    ext_order = OW'(order);
    if (ext_order == '0) begin
      eff_order = OW'(1);
    end else if (ext_order > OW'(MAX_ORDER)) begin
      eff_order = OW'(MAX_ORDER);
    end else begin
      eff_order = ext_order;
    end
  end

  logic [CNT_W-1:0] fill_count;
  logic             warm_now;
  assign warm_now = OW'(fill_count) < eff_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept && (fill_count < CNT_W'(MAX_ORDER))) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  logic signed [SAMPLE_WIDTH-1:0] taps  [0:MAX_ORDER];
  logic signed [PW-1:0]           prods [0:MAX_ORDER];

  assign taps[0] = sample_in;

  genvar k;
  generate
    for (k = 0; k <= MAX_ORDER; k++) begin : g_cell
      logic signed [COEF_WIDTH-1:0] coef_k;
      if (k < NUM_COEFS) begin : g_coef
        assign coef_k = (OW'(k) <= eff_order) ? $signed(coefs[k]) : '0;
      end else begin : g_zero
        assign coef_k = '0;
      end
      if (k < MAX_ORDER) begin : g_mid
        fir5_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .HAS_TAP(1'b1)) u_cell (
          .clk     (clk),
          .rst     (rst),
          .ctrl    (ctrl),
          .data_in (taps[k]),
          .coef    (coef_k),
          .tap_out (taps[k+1]),
          .prod    (prods[k])
        );
      end else begin : g_last
        fir5_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .HAS_TAP(1'b0)) u_cell (
          .clk     (clk),
          .rst     (rst),
          .ctrl    (ctrl),
          .data_in (taps[k]),
          .coef    (coef_k),
          .tap_out (),
          .prod    (prods[k])
        );
      end
    end
  endgenerate

  // stage 1 and stage 2 side data, and the sum
  logic signed [SAMPLE_WIDTH-1:0] x1, x2;
  logic                           warm1, warm2;
  logic signed [ACC_W-1:0]        sum2, sum_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      sum_next = sum_next + ACC_W'(prods[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= sample_valid;
      if (adv2) v2 <= v1;
      if (adv3) result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      x1    <= sample_in;
      warm1 <= warm_now;
    end
    if (adv2) begin
      x2    <= x1;
      warm2 <= warm1;
      sum2  <= sum_next;
    end
  end

  // round half up, shift, saturate
  logic signed [RW-1:0]           rnd;
  logic signed [QW-1:0]           q;
  logic [QW-SAMPLE_WIDTH:0]       hi;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  assign rnd = RW'(sum2) + RW'(ROUND_BIAS);
  assign q   = QW'(rnd >>> COEF_FRAC);
  assign hi  = q[QW-1:SAMPLE_WIDTH-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      sat = q[SAMPLE_WIDTH-1:0];
    end else if (q[QW-1]) begin
      sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      filtered_out <= warm2 ? x2 : sat;
      warming      <= warm2;
    end
  end

endmodule
